### hw/rtl/ggtmd_pkg.sv
// shared types and constants for the gyro gesture toggle motor drive
package ggtmd_pkg;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_EXT_THR  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FLX_THR  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RUN_CD   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RESTART  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPEED    = 3'd4;

  localparam int unsigned CfgDataW = 16;

  // register reset values
  localparam logic signed [15:0] EXT_THR_RST = -16'sd1792;
  localparam logic signed [15:0] FLX_THR_RST = 16'sd1792;
  localparam logic [15:0]        RUN_CD_RST  = 16'd500;
  localparam logic [15:0]        RESTART_RST = 16'd1000;
  localparam logic [14:0]        SPEED_RST   = 15'd256;

  // angle limits in signed Q8.8: 5 and 88 degrees
  localparam logic signed [15:0] ANGLE_LOW  = 16'sd1280;
  localparam logic signed [15:0] ANGLE_HIGH = 16'sd22528;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 24;

  typedef struct packed {
    logic signed [15:0] ext_thr;
    logic signed [15:0] flx_thr;
    logic [15:0]        run_cd;
    logic [15:0]        restart_cd;
    logic [14:0]        speed;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [15:0] elbow_deg;
    logic signed [15:0] gyro_rate;
  } sample_t;

  typedef struct packed {
    logic               flexing;
    logic               extending;
    logic signed [15:0] velocity_cmd;
  } result_t;

endpackage

### hw/rtl/ggtmd_cfg.sv
// configuration register file
module ggtmd_cfg
  import ggtmd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_EXT_THR: cfg_nxt.ext_thr    = $signed(wr_data);
        CFG_FLX_THR: cfg_nxt.flx_thr    = $signed(wr_data);
        CFG_RUN_CD:  cfg_nxt.run_cd     = wr_data;
        CFG_RESTART: cfg_nxt.restart_cd = wr_data;
        CFG_SPEED:   cfg_nxt.speed      = wr_data[14:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ext_thr    <= EXT_THR_RST;
      cfg_r.flx_thr    <= FLX_THR_RST;
      cfg_r.run_cd     <= RUN_CD_RST;
      cfg_r.restart_cd <= RESTART_RST;
      cfg_r.speed      <= SPEED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/ggtmd_core.sv
// gesture toggle state and velocity decision for one sample
module ggtmd_core
  import ggtmd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    upd,
  input  sample_t smp,
  input  cfg_t    cfg,
  output result_t res
);

  logic signed [15:0] held_r, held_nxt;
  logic               ea_r, ea_nxt, ems_r, ems_nxt;
  logic [31:0]        est_r, est_nxt, esp_r, esp_nxt;
  logic               fa_r, fa_nxt, fms_r, fms_nxt;
  logic [31:0]        fst_r, fst_nxt, fsp_r, fsp_nxt;
  logic               ext_g, flx_g;
  logic [31:0]        restart_w, run_w;
  logic signed [15:0] pos_speed, neg_speed;

  assign ext_g     = smp.gyro_rate < cfg.ext_thr;
  assign flx_g     = smp.gyro_rate > cfg.flx_thr;
  assign restart_w = {16'd0, cfg.restart_cd};
  assign run_w     = {16'd0, cfg.run_cd};
  assign pos_speed = $signed({1'b0, cfg.speed});
  assign neg_speed = -pos_speed;

  // extend side, then flex side, then angle cut
  always_comb begin
    held_nxt = held_r;
    ea_nxt   = ea_r;
    ems_nxt  = ems_r;
    est_nxt  = est_r;
    esp_nxt  = esp_r;
    fa_nxt   = fa_r;
    fms_nxt  = fms_r;
    fst_nxt  = fst_r;
    fsp_nxt  = fsp_r;

    if (ext_g && !ea_nxt && ((smp.now_ms - esp_nxt) > restart_w)) begin
      held_nxt = pos_speed;
      est_nxt  = smp.now_ms;
      ea_nxt   = 1'b1;
      ems_nxt  = 1'b0;
    end
    if (ea_nxt && ((smp.now_ms - est_nxt) > run_w)) begin
      ems_nxt = 1'b1;
    end
    if (ems_nxt && ext_g) begin
      held_nxt = '0;
      ea_nxt   = 1'b0;
      ems_nxt  = 1'b0;
      esp_nxt  = smp.now_ms;
    end

    if (flx_g && !fa_nxt && ((smp.now_ms - fsp_nxt) > restart_w)) begin
      held_nxt = neg_speed;
      fst_nxt  = smp.now_ms;
      fa_nxt   = 1'b1;
      fms_nxt  = 1'b0;
    end
    if (fa_nxt && ((smp.now_ms - fst_nxt) > run_w)) begin
      fms_nxt = 1'b1;
    end
    if (fms_nxt && flx_g) begin
      held_nxt = '0;
      fa_nxt   = 1'b0;
      fms_nxt  = 1'b0;
      fsp_nxt  = smp.now_ms;
    end

    if ((smp.elbow_deg <= ANGLE_LOW) && (held_nxt < 16'sd0)) begin
      held_nxt = '0;
    end
    if ((smp.elbow_deg >= ANGLE_HIGH) && (held_nxt > 16'sd0)) begin
      held_nxt = '0;
    end
  end

  // state update on each sample that moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      ea_r   <= 1'b0;
      ems_r  <= 1'b0;
      est_r  <= '0;
      esp_r  <= '0;
      fa_r   <= 1'b0;
      fms_r  <= 1'b0;
      fst_r  <= '0;
      fsp_r  <= '0;
    end else if (upd) begin
      held_r <= held_nxt;
      ea_r   <= ea_nxt;
      ems_r  <= ems_nxt;
      est_r  <= est_nxt;
      esp_r  <= esp_nxt;
      fa_r   <= fa_nxt;
      fms_r  <= fms_nxt;
      fst_r  <= fst_nxt;
      fsp_r  <= fsp_nxt;
    end
  end

  assign res.velocity_cmd = held_nxt;
  assign res.extending    = ea_nxt;
  assign res.flexing      = fa_nxt;

endmodule

### hw/rtl/gyro_gesture_toggle_motor_drive_top.sv
// top level of the gyro gesture toggle motor drive
//
// channel | direction | handshake            | payload
// in_     | slave     | in_tvalid/in_tready  | in_tdata 64 bit sample
// out_    | master    | out_tvalid/out_tready| out_tdata 24 bit result
// cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index 3 bit, cfg_data 16 bit
//
// one sample a cycle sustained while out_tready stays high; the stages are the
// input register, then the gesture logic in ggtmd_core feeding the result register
// rst_n is synchronous; it clears the run state, the valid flags and loads
// the register reset values
// a stalled result holds the input register; in_tready follows out_tready
// through the two stages, and cfg_ready is always high
module gyro_gesture_toggle_motor_drive_top
  import ggtmd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // gyro_rate[15:0], elbow_deg[31:16], now_ms[63:32]
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // velocity_cmd[15:0], extending[16], flexing[17], zero[23:18]
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg;
  sample_t smp_r;
  logic    smp_vld_r;
  result_t res;
  result_t res_r;
  logic    out_vld_r;
  logic    adv;

  assign cfg_ready = 1'b1;

  ggtmd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // result register free or emptying this cycle
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !smp_vld_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
    end else if (in_tready) begin
      smp_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      smp_r <= sample_t'(in_tdata);
    end
  end

  ggtmd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (smp_vld_r & adv),
    .smp   (smp_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= smp_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && smp_vld_r) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, res_r};

`ifndef ASSERT_OFF
  // a positive command only comes from a running extend
  a_pos_extend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ($signed(out_tdata[15:0]) > 16'sd0)) |-> out_tdata[16])
    else $error("positive velocity without extend run");

  // a negative command only comes from a running flex
  a_neg_flex: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ($signed(out_tdata[15:0]) < 16'sd0)) |-> out_tdata[17])
    else $error("negative velocity without flex run");

  // both stages full and stalled: no new sample taken
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (smp_vld_r && out_vld_r && !out_tready) |-> !in_tready)
    else $error("sample accepted while pipeline is full");

  // an accepted sample lands in the input register
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> smp_vld_r)
    else $error("accepted sample lost");
`endif

endmodule

### test/ggtmd_checker.sv
// checker for the gesture motor drive: predicts every result and compares it field by field
`timescale 1ns / 100ps
module ggtmd_checker
  import ggtmd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  results_pending,
  output int                  results_seen
);

  localparam int PrintCap = 100;

  // predictor copy of the registers and the run state
  cfg_t               drive_cfg;
  logic signed [15:0] held_vel;
  logic               ext_run;
  logic               ext_stoppable;
  logic               flx_run;
  logic               flx_stoppable;
  logic [31:0]        ext_start;
  logic [31:0]        ext_stop;
  logic [31:0]        flx_start;
  logic [31:0]        flx_stop;

  // drive commands still owed by the block, oldest first
  result_t            expected_cmds[$];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (fail_count < PrintCap)
      $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    fail_count++;
  endtask

  // one sensor sample through the gesture toggle and angle cut
  function automatic result_t drive_step(input sample_t s);
    logic signed [15:0] rate;
    logic signed [15:0] angle;
    logic signed [15:0] ext_thr;
    logic signed [15:0] flx_thr;
    logic signed [15:0] speed_pos;
    logic [31:0]        since;
    logic               ext_gest;
    logic               flx_gest;
    result_t            r;
    rate      = s.gyro_rate;
    angle     = s.elbow_deg;
    ext_thr   = drive_cfg.ext_thr;
    flx_thr   = drive_cfg.flx_thr;
    speed_pos = {1'b0, drive_cfg.speed};
    ext_gest  = rate < ext_thr;
    flx_gest  = rate > flx_thr;

    // extend side
    since = s.now_ms - ext_stop;
    if (ext_gest && !ext_run && since > {16'd0, drive_cfg.restart_cd}) begin
      held_vel      = speed_pos;
      ext_start     = s.now_ms;
      ext_run       = 1'b1;
      ext_stoppable = 1'b0;
    end
    since = s.now_ms - ext_start;
    if (ext_run && since > {16'd0, drive_cfg.run_cd})
      ext_stoppable = 1'b1;
    if (ext_stoppable && ext_gest) begin
      held_vel      = '0;
      ext_run       = 1'b0;
      ext_stoppable = 1'b0;
      ext_stop      = s.now_ms;
    end

    // flex side, last so it wins the velocity
    since = s.now_ms - flx_stop;
    if (flx_gest && !flx_run && since > {16'd0, drive_cfg.restart_cd}) begin
      held_vel      = -speed_pos;
      flx_start     = s.now_ms;
      flx_run       = 1'b1;
      flx_stoppable = 1'b0;
    end
    since = s.now_ms - flx_start;
    if (flx_run && since > {16'd0, drive_cfg.run_cd})
      flx_stoppable = 1'b1;
    if (flx_stoppable && flx_gest) begin
      held_vel      = '0;
      flx_run       = 1'b0;
      flx_stoppable = 1'b0;
      flx_stop      = s.now_ms;
    end

    // angle limits
    if (angle <= ANGLE_LOW && held_vel < 0)
      held_vel = '0;
    if (angle >= ANGLE_HIGH && held_vel > 0)
      held_vel = '0;

    r.velocity_cmd = held_vel;
    r.extending    = ext_run;
    r.flexing      = flx_run;
    return r;
  endfunction

  // watch the three channels at each edge
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      fail_count    = 0;
      results_seen  = 0;
      drive_cfg     = '{EXT_THR_RST, FLX_THR_RST, RUN_CD_RST, RESTART_RST, SPEED_RST};
      held_vel      = '0;
      ext_run       = 1'b0;
      ext_stoppable = 1'b0;
      ext_start     = '0;
      ext_stop      = '0;
      flx_run       = 1'b0;
      flx_stoppable = 1'b0;
      flx_start     = '0;
      flx_stop      = '0;
      expected_cmds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_EXT_THR: drive_cfg.ext_thr    = cfg_data;
          CFG_FLX_THR: drive_cfg.flx_thr    = cfg_data;
          CFG_RUN_CD:  drive_cfg.run_cd     = cfg_data;
          CFG_RESTART: drive_cfg.restart_cd = cfg_data;
          CFG_SPEED:   drive_cfg.speed      = cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_cmds.push_back(drive_step(sample_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = result_t'(out_tdata[17:0]);
        if (expected_cmds.size() == 0) begin
          report_mismatch("result with no sample waiting", '0, 32'(out_tdata));
        end else begin
          want = expected_cmds.pop_front();
          if (got.velocity_cmd !== want.velocity_cmd)
            report_mismatch("velocity_cmd", 32'(want.velocity_cmd), 32'(got.velocity_cmd));
          if (got.extending !== want.extending)
            report_mismatch("extending", 32'(want.extending), 32'(got.extending));
          if (got.flexing !== want.flexing)
            report_mismatch("flexing", 32'(want.flexing), 32'(got.flexing));
          if (out_tdata[OutDataW-1:18] !== '0)
            report_mismatch("padding bits", '0, 32'(out_tdata[OutDataW-1:18]));
        end
      end
    end
    results_pending <= expected_cmds.size();
  end

endmodule

### test/tb_top.sv
// testbench top for the gesture motor drive: stimulus, handshake idling and the verdict
`timescale 1ns / 100ps
module tb_top;
  import ggtmd_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 400;
  localparam int NumSettings   = 5;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  int fail_count;
  int results_pending;
  int results_seen;
  int hold_off_want = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;
  int samples_sent  = 0;
  int reg_writes    = 0;

  // running timestamp and the current settings, used only to aim the stimulus
  logic [31:0] stamp;
  cfg_t        aim;
  int          step_max;

  always #4 clk = ~clk;

  gyro_gesture_toggle_motor_drive_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ggtmd_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_pending (results_pending),
    .results_seen    (results_seen)
  );

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("gyro_gesture_toggle_motor_drive_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: randomly chosen stall patterns, plus long hold-offs
  initial begin : receiver
    int mode;
    int served;
    int left;
    mode   = 0;
    served = 0;
    left   = 0;
    forever begin
      @(posedge clk);
      if (served < hold_off_want) begin
        served++;
        out_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 7) == 0);
        default: out_tready <= ~out_tready;
      endcase
    end
  end

  // one sample transaction, sent in bursts with random gaps between them
  task automatic send_sample(input sample_t s);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  task automatic send_fields(input logic [31:0] t, input int rate, input int angle);
    send_sample('{t, 16'(angle), 16'(rate)});
  endtask

  // leaves valid high; the caller lowers it after the last write
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  // all registers, the speed with a random spare top bit, then one unused index
  task automatic apply_setting(input cfg_t c);
    put_reg(CFG_EXT_THR, c.ext_thr);
    put_reg(CFG_FLX_THR, c.flx_thr);
    put_reg(CFG_RUN_CD, c.run_cd);
    put_reg(CFG_RESTART, c.restart_cd);
    put_reg(CFG_SPEED, {1'($urandom_range(0, 1)), c.speed});
    put_reg(CfgIdxW'($urandom_range(int'(CFG_SPEED) + 1, (1 << CfgIdxW) - 1)),
            16'($urandom));
    cfg_valid <= 1'b0;
    aim = c;
  endtask

  // drain: stop offering, wait for every owed result, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // gestures aimed around the current thresholds, time steps matched to the cooldowns
  function automatic sample_t random_sample();
    sample_t            s;
    logic signed [15:0] ext_thr;
    logic signed [15:0] flx_thr;
    int                 pick;
    int                 rate;
    int                 angle;
    int                 lo;
    int                 hi;
    ext_thr = aim.ext_thr;
    flx_thr = aim.flx_thr;

    pick = $urandom_range(0, 99);
    if (pick < 4)
      stamp = $urandom;
    else if (pick < 7)
      stamp = stamp - $urandom_range(1, 2000);
    else if (pick >= 15)
      stamp = stamp + $urandom_range(0, step_max);

    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      rate = ext_thr;
      rate = rate - int'($urandom_range(1, 600));
    end else if (pick < 70) begin
      rate = flx_thr;
      rate = rate + int'($urandom_range(1, 600));
    end else if (pick < 88) begin
      lo = ext_thr;
      hi = flx_thr;
      if (lo > hi) begin
        lo = flx_thr;
        hi = ext_thr;
      end
      rate = lo + int'($urandom_range(0, hi - lo));
    end else begin
      rate = $signed(16'($urandom));
    end
    if (rate < -32768) rate = -32768;
    if (rate > 32767) rate = 32767;

    pick = $urandom_range(0, 99);
    if (pick < 70)
      angle = int'($urandom_range(int'(ANGLE_LOW) + 1, int'(ANGLE_HIGH) - 1));
    else if (pick < 75)
      angle = (pick < 73) ? int'(ANGLE_LOW) : int'(ANGLE_HIGH);
    else if (pick < 82)
      angle = int'(ANGLE_LOW) - int'($urandom_range(0, 3000));
    else if (pick < 89)
      angle = int'(ANGLE_HIGH) + int'($urandom_range(0, 3000));
    else
      angle = $signed(16'($urandom));

    s.now_ms    = stamp;
    s.elbow_deg = 16'(angle);
    s.gyro_rate = 16'(rate);
    return s;
  endfunction

  initial begin : stimulus
    cfg_t        setting [NumSettings];
    int          count   [NumSettings];
    int          steps   [NumSettings];
    logic [31:0] starts  [NumSettings];
    // fast toggling, full speed
    setting[0] = '{-16'sd256, 16'sd256, 16'd20, 16'd40, 15'h7FFF};
    count[0] = 300; steps[0] = 60; starts[0] = 32'd0;
    // thresholds at the ends, so no gesture can fire; zero cooldowns and speed
    setting[1] = '{-16'sd32768, 16'sd32767, 16'd0, 16'd0, 15'd0};
    count[1] = 50; steps[1] = 100; starts[1] = 32'd5000;
    // crossed thresholds: both gestures in one sample
    setting[2] = '{16'sd32767, -16'sd32768, 16'd0, 16'd0, 15'd1};
    count[2] = 250; steps[2] = 5; starts[2] = 32'd90000;
    // longest cooldowns, timestamps running through the wrap
    setting[3] = '{16'sd0, 16'sd0, 16'hFFFF, 16'hFFFF, 15'd12345};
    count[3] = 250; steps[3] = 40000; starts[3] = 32'hFFF0_0000;
    // ordinary mid-range setting
    setting[4] = '{-16'sd1000, 16'sd1500, 16'd300, 16'd600, 15'h2AAA};
    count[4] = 380; steps[4] = 300; starts[4] = 32'h4000_0000;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    aim = '{EXT_THR_RST, FLX_THR_RST, RUN_CD_RST, RESTART_RST, SPEED_RST};

    // directed walk through the toggle under the reset settings
    send_fields(32'd0, -32768, 0);          // gesture still inside the cooldown after reset
    send_fields(32'd1001, -1793, 10000);    // extend starts just past the threshold
    send_fields(32'd1200, -32768, 10000);   // too early to stop
    send_fields(32'd1400, 0, 22528);        // extending at the upper angle limit
    send_fields(32'd1502, -1793, 10000);    // extend stops
    send_fields(32'd1600, 1793, 10000);     // flex starts
    send_fields(32'd1700, -1793, 10000);    // extend restart still cooling down
    send_fields(32'd2600, -1792, 10000);    // rate equal to threshold is no gesture
    send_fields(32'd2601, 32767, 10000);    // flex stops
    send_fields(32'd2700, -32768, 10000);   // extend starts again
    send_fields(32'd3700, 32767, 10000);    // flex starts and takes the velocity
    send_fields(32'd4300, -32768, 10000);   // extend stops while flexing
    send_fields(32'd4400, 32767, 1280);     // flex stops at the lower angle limit
    send_fields(32'd5500, -32768, -32768);  // extend at the lowest angle
    send_fields(32'd5600, 32767, 32767);    // flex at the highest angle
    send_fields(32'd6200, 32767, 10000);    // flex stop while extending: zero, extending set
    send_fields(32'd7300, 32767, -32768);   // flex start cut at the lower limit
    send_fields(32'hFFFF_FF00, -32768, 10000);
    send_fields(32'h0000_0300, -32768, 10000); // restart measured across the wrap
    send_fields(32'hFFFF_FFFF, 0, 32767);
    send_fields(32'd0, 0, -32768);

    // random under the reset settings, with one long result stall
    stamp    = 32'd10000;
    step_max = 400;
    for (int i = 0; i < 300; i++) begin
      if (i == 100) hold_off_want <= hold_off_want + 1;
      send_sample(random_sample());
    end

    for (int p = 0; p < NumSettings; p++) begin
      wait_idle();
      apply_setting(setting[p]);
      stamp    = starts[p];
      step_max = steps[p];
      for (int i = 0; i < count[p]; i++)
        send_sample(random_sample());
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d samples, %0d register writes over %0d settings, %0d results checked",
             samples_sent, reg_writes, NumSettings + 1, results_seen);
    $display("incl. crossed and end-of-range thresholds, zero and full cooldowns, "
             , "timestamp wrap and a long result stall");
    if (fail_count == 0)
      $display("gyro_gesture_toggle_motor_drive_top test passed");
    else
      $display("gyro_gesture_toggle_motor_drive_top test failed");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ggtmd_pkg.sv
hw/rtl/ggtmd_cfg.sv
hw/rtl/ggtmd_core.sv
hw/rtl/gyro_gesture_toggle_motor_drive_top.sv
test/ggtmd_checker.sv
test/tb_top.sv
